// File: design/lsws_pkg.sv
package lsws_pkg;

  // Default number of stored words
  localparam int DEPTH_DEF = 16;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
  } lsws_in_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } lsws_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_in;    // capture the input transaction
    logic apply;      // execute a non-search command and load its result
    logic srch_init;  // clear the search pointers
    logic srch_step;  // advance the search by one word
    logic srch_fin;   // load the search result
  } lsws_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_search;
    logic srch_done;
    logic out_free;
  } lsws_sts_t;

endpackage

// File: design/lsws_ram.sv
module lsws_ram import lsws_pkg::*; #(
  parameter int WIDTH = VALUE_W,
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lsws_ctrl.sv
module lsws_ctrl import lsws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lsws_sts_t sts,
  output lsws_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SFIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_search) begin
          ctl.srch_init = 1'b1;
          state_nxt     = S_SEARCH;
        end else if (sts.out_free) begin
          ctl.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        ctl.srch_step = 1'b1;
        if (sts.srch_done) begin
          state_nxt = S_SFIN;
        end
      end
      S_SFIN: begin
        if (sts.out_free) begin
          ctl.srch_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/lsws_dp.sv
module lsws_dp import lsws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lsws_in_t  in_data,
  input  lsws_ctl_t ctl,
  output lsws_sts_t sts,
  output logic      out_valid,
  input  logic      out_ready,
  output lsws_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lsws_in_t          in_r;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rd_off_r;
  logic              cmp_vld_r;
  logic [CW-1:0]     cmp_off_r;
  logic [POS_W-1:0]  spos_r;
  logic              out_valid_r;
  lsws_out_t         out_r, res;

  logic              we;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [VALUE_W-1:0] rdata;
  logic              full, empty, match, rd_more, done, out_free;

  // Ring position of an offset from the front; offset is at most DEPTH
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] front,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, front} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  lsws_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_r.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign match    = cmp_vld_r && (rdata == in_r.value);
  assign rd_more  = (rd_off_r < cnt_r);
  assign done     = match || (!cmp_vld_r && !rd_more);
  assign out_free = !out_valid_r || out_ready;

  assign sts.is_search = (in_r.cmd == CMD_SEARCH);
  assign sts.srch_done = done;
  assign sts.out_free  = out_free;

  assign raddr = ring_at(front_r, rd_off_r);
  assign re    = ctl.srch_step && !done && rd_more;

  // Execute add, remove and count
  always_comb begin
    front_nxt    = front_r;
    cnt_nxt      = cnt_r;
    we           = 1'b0;
    waddr        = ring_at(front_r, cnt_r);
    res.position = '0;
    res.status   = STAT_OK;
    case (in_r.cmd)
      CMD_ADD_FRONT: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
          waddr     = front_nxt;
          we        = ctl.apply;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      CMD_ADD_BACK: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          we      = ctl.apply;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      CMD_REM_FRONT: begin
        if (empty) begin
          res.status = STAT_EMPTY;
        end else begin
          front_nxt = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      CMD_REM_BACK: begin
        if (empty) begin
          res.status = STAT_EMPTY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(cnt_nxt);
  end

  // Hold the input transaction
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      in_r <= in_data;
    end
  end

  // Ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (ctl.apply) begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Search walk: read one word a cycle, compare it in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      rd_off_r  <= '0;
    end else if (ctl.srch_init) begin
      cmp_vld_r <= 1'b0;
      rd_off_r  <= '0;
    end else if (ctl.srch_step && !done) begin
      cmp_vld_r <= rd_more;
      if (rd_more) begin
        rd_off_r <= rd_off_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.srch_step && !done && rd_more) begin
      cmp_off_r <= rd_off_r;
    end
    if (ctl.srch_step && done) begin
      spos_r <= match ? POS_W'(cmp_off_r + 1'b1) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.apply || ctl.srch_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      out_r <= res;
    end else if (ctl.srch_fin) begin
      out_r.position <= spos_r;
      out_r.count    <= COUNT_W'(cnt_r);
      out_r.status   <= STAT_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/list_store_with_search.sv
// Double-ended store of up to DEPTH signed 32-bit words with linear search.
// Input channel (in_valid/in_ready/in_data) carries one command per
// transaction: add front, add back, remove front, remove back, count, search.
// Result channel (out_valid/out_ready/out_data) returns exactly one
// transaction per command: match position, count after the command, status.
// Adds, removals and count execute once the output register is free and load
// their result there; the next command is accepted back in the idle state.
// A search walks the stored words from the front through the single RAM
// read port, one word per cycle, with a registered read feeding the compare,
// stops at the first match or after the last stored word, and the next command
// can be accepted once the search result is loaded.
// One command is worked at a time; in_ready is high only in the idle state.
// The result sits in an output register, so the next command is accepted
// while a finished result still waits for out_ready; a stalled receiver
// holds out_data steady and stops the block only once a new result is due.
// Synchronous active-low reset empties the store (front and count to zero)
// and drops any pending result; the word RAM itself is not cleared.
module list_store_with_search import lsws_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lsws_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lsws_out_t out_data
);

  lsws_ctl_t ctl;
  lsws_sts_t sts;

  lsws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lsws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_list_store_with_search.sv
`timescale 1ns / 100ps

module tb_list_store_with_search;
  import lsws_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 8;
  localparam int RECENT_MAX   = 16;

  // Command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] WORD_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] WORD_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {PH_RECV_SLOW, PH_SEND_SLOW, PH_FREE} phase_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lsws_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lsws_out_t out_data;

  // Stimulus and scoreboard
  lsws_in_t           pending_items[$];
  lsws_out_t          expected_results[$];
  logic [VALUE_W-1:0] recent_words[$];
  lsws_out_t          oldest_result;
  int                 error_count = 0;
  int                 cycle_count = 0;
  phase_t             phase = PH_RECV_SLOW;
  int                 sender_idle_pct = 0;
  int                 receiver_idle_pct = 0;
  int                 hold_left = 0;
  logic               long_hold_done = 1'b0;

  // Shadow of the deque
  logic [VALUE_W-1:0] shadow_words [DEPTH_DEF];
  int                 shadow_front = 0;
  int                 shadow_count = 0;

  list_store_with_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one command to the shadow deque and return the result it should give
  function automatic lsws_out_t apply_command(input lsws_in_t item);
    lsws_out_t res;
    logic      found;
    res = '0;
    res.status = STAT_OK;
    found = 1'b0;
    case (item.cmd)
      CMD_ADD_FRONT: begin
        if (shadow_count >= DEPTH_DEF) begin
          res.status = STAT_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH_DEF - 1) % DEPTH_DEF;
          shadow_words[shadow_front] = item.value;
          shadow_count++;
        end
      end
      CMD_ADD_BACK: begin
        if (shadow_count >= DEPTH_DEF) begin
          res.status = STAT_FULL;
        end else begin
          shadow_words[(shadow_front + shadow_count) % DEPTH_DEF] = item.value;
          shadow_count++;
        end
      end
      CMD_REM_FRONT: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % DEPTH_DEF;
          shadow_count--;
        end
      end
      CMD_REM_BACK: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (!found && shadow_words[(shadow_front + i) % DEPTH_DEF] == item.value) begin
            res.position = POS_W'(i + 1);
            found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    lsws_in_t item;
    item.cmd = cmd;
    item.value = value;
    pending_items.push_back(item);
  endtask

  // Often small values, so duplicates and hits are common
  function automatic logic [VALUE_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      return VALUE_W'($urandom_range(0, 7));
    end else if (roll < 40) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // Queue random commands in runs that lean toward filling, draining or mixing
  task automatic queue_random_items(input int n);
    lsws_in_t item;
    int       mode;
    int       run_left;
    int       roll;
    int       add_lim;
    int       srch_lim;
    int       rem_lim;
    mode = 0;
    run_left = 0;
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        mode = $urandom_range(0, 2);
        run_left = $urandom_range(8, 28);
      end
      run_left--;
      case (mode)
        0:       begin add_lim = 60; srch_lim = 80; rem_lim = 90; end
        1:       begin add_lim = 20; srch_lim = 35; rem_lim = 85; end
        default: begin add_lim = 35; srch_lim = 60; rem_lim = 85; end
      endcase
      roll = $urandom_range(0, 99);
      item.value = $urandom();
      if (roll < add_lim) begin
        item.cmd = $urandom_range(0, 1) ? CMD_ADD_FRONT : CMD_ADD_BACK;
        item.value = pick_word();
        recent_words.push_back(item.value);
        if (recent_words.size() > RECENT_MAX) begin
          void'(recent_words.pop_front());
        end
      end else if (roll < srch_lim) begin
        item.cmd = CMD_SEARCH;
        if (recent_words.size() != 0 && $urandom_range(0, 1)) begin
          item.value = recent_words[$urandom_range(0, recent_words.size() - 1)];
        end else begin
          item.value = pick_word();
        end
      end else if (roll < rem_lim) begin
        item.cmd = $urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK;
      end else if (roll < 95) begin
        item.cmd = CMD_COUNT;
      end else begin
        item.cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      end
      pending_items.push_back(item);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: record accepted transactions, then offer the next pending item
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_command(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %h", out_data);
          error_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data.position !== oldest_result.position) begin
            $error("position: expected %0d, actual %0d", oldest_result.position,
                   out_data.position);
            error_count++;
          end
          if (out_data.count !== oldest_result.count) begin
            $error("count: expected %0d, actual %0d", oldest_result.count, out_data.count);
            error_count++;
          end
          if (out_data.status !== oldest_result.status) begin
            $error("status: expected %0d, actual %0d", oldest_result.status,
                   out_data.status);
            error_count++;
          end
        end
      end
      // Pace the receiver; hold off once for a long stretch in the last phase
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (phase == PH_FREE && !long_hold_done) begin
        out_ready <= 1'b0;
        hold_left <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_list_store_with_search: errors");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Slow receiver: directed corners first, then random traffic
    phase = PH_RECV_SLOW;
    sender_idle_pct = 14;
    receiver_idle_pct = 81;
    queue_item(CMD_REM_FRONT, '0);
    queue_item(CMD_REM_BACK, '1);
    queue_item(CMD_SEARCH, '0);
    queue_item(CMD_COUNT, '0);
    // remove the only word from either end
    queue_item(CMD_ADD_FRONT, WORD_MIN);
    queue_item(CMD_REM_FRONT, '0);
    queue_item(CMD_ADD_BACK, WORD_MAX);
    queue_item(CMD_REM_BACK, '0);
    // fill from both ends, then add to a full store
    for (int i = 0; i < DEPTH_DEF; i++) begin
      if (i % 2 == 0) begin
        queue_item(CMD_ADD_FRONT, VALUE_W'(100 + i));
      end else begin
        queue_item(CMD_ADD_BACK, VALUE_W'(200 + i));
      end
    end
    queue_item(CMD_ADD_FRONT, WORD_MAX);
    queue_item(CMD_SEARCH, VALUE_W'(200 + DEPTH_DEF - 1));
    queue_item(CMD_SPARE_LO, WORD_MIN);
    queue_random_items(225);
    wait_drained();

    // Slow sender
    phase = PH_SEND_SLOW;
    sender_idle_pct = 81;
    receiver_idle_pct = 14;
    queue_random_items(250);
    wait_drained();

    // No idling, apart from one long receiver hold-off
    phase = PH_FREE;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_random_items(250);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_list_store_with_search: clean");
    end else begin
      $display("tb_list_store_with_search: errors");
    end
    $finish;
  end

endmodule
